/* sv/ilse_pkg.sv */
`default_nettype none
package ilse_pkg;
  localparam int NCH       = 5;
  localparam int NORM_BITS = 13;
  localparam int NORM_MAX  = 8191;
  localparam int LOST_TH   = 280;
  localparam int COMP_TH   = 500;
  localparam int LOST_ERR  = 500;
  // Rounds summed per result; a power of two so the average is a shift.
  localparam int ROUNDS_PER_RESULT = 8;

  localparam logic [2:0] CFG_MAX_MIDDLE     = 3'd0;
  localparam logic [2:0] CFG_MAX_LEFT       = 3'd1;
  localparam logic [2:0] CFG_MAX_RIGHT      = 3'd2;
  localparam logic [2:0] CFG_MAX_VERT_LEFT  = 3'd3;
  localparam logic [2:0] CFG_MAX_VERT_RIGHT = 3'd4;

  typedef enum logic [3:0] {
    ST_ACC, ST_NORM_START, ST_NORM_WAIT, ST_H1, ST_H1W, ST_H2, ST_H2W,
    ST_V1, ST_V1W, ST_V2, ST_V2W, ST_COMP, ST_COMPW, ST_BLEND, ST_OUT
  } state_t;
endpackage
`default_nettype wire

/* sv/ilse_div.sv */
`default_nettype none
// Unsigned restoring divider, one quotient bit per cycle.
module ilse_div import ilse_pkg::*; #(
  parameter int W = 32
) (
  input  wire  logic         clk,
  input  wire  logic         rst,
  input  wire  logic         start,
  input  wire  logic [W-1:0] dividend,
  input  wire  logic [W-1:0] divisor,
  output logic               busy,
  output logic [W-1:0]       quotient
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic [W:0]    trial;

  assign trial    = {rem, quo[W-1]} - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(W);
      rem  <= '0;
      quo  <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      if (trial[W]) begin
        rem <= {rem[W-2:0], quo[W-1]};
        quo <= {quo[W-2:0], 1'b0};
      end else begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

/* sv/ilse_lane.sv */
`default_nettype none
// One sensor channel: accumulate samples, then average and normalize.
module ilse_lane import ilse_pkg::*; #(
  parameter int SAMPLE_BITS = 12,
  parameter int SUM_BITS    = 15,
  parameter int RSH         = 3
) (
  input  wire  logic                   clk,
  input  wire  logic                   rst,
  input  wire  logic                   add,
  input  wire  logic [SAMPLE_BITS-1:0] sample,
  input  wire  logic                   start,
  input  wire  logic [11:0]            maxv,
  output logic                         busy,
  output logic [NORM_BITS-1:0]         norm
);
  localparam int DW = 32;
  logic [SUM_BITS-1:0] sum;
  logic [DW-1:0]       avg;
  logic [DW-1:0]       lo;
  logic [DW-1:0]       quo;
  logic                neg;
  logic                neg_r;
  logic [DW-1:0]       num;
  logic [DW-1:0]       den;
  logic                dbusy;

  assign avg = DW'(sum >> RSH);
  assign lo  = DW'((32'(maxv) * 32'd3277) >> 16);  // maxv / 20 for 12 bits
  assign neg = avg < lo;
  assign num = 32'd1000 * (neg ? (lo - avg) : (avg - lo));
  assign den = 32'd1000 - lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      neg_r <= 1'b0;
    end else begin
      if (add) sum <= sum + SUM_BITS'(sample);
      if (start) begin
        sum   <= '0;
        neg_r <= neg;
      end
    end
  end

  ilse_div #(.W(DW)) u_div (
    .clk, .rst, .start, .dividend(num), .divisor(den), .busy(dbusy), .quotient(quo)
  );
  assign busy = dbusy;

  always_comb begin
    if (neg_r || quo == '0) norm = NORM_BITS'(1);
    else if (quo > DW'(NORM_MAX)) norm = NORM_BITS'(NORM_MAX);
    else norm = quo[NORM_BITS-1:0];
  end
endmodule
`default_nettype wire

/* sv/inductive_line_steer_error.sv */
`default_nettype none
// Channel   | Direction | Handshake        | Payload
// in        | input     | in_valid/ready   | sample_middle .. sample_vert_right
// out       | output    | out_valid/ready  | steer_error, line_lost, middle_peak
// cfg       | input     | cfg_we           | cfg_index, cfg_data
//
// A round that does not complete a block is taken without leaving the
// accumulate state. The closing round starts five lane dividers in the
// following cycle, and the merge waits in the wait state for them; it then
// runs four ratio divisions and one compensation division on a shared 48-bit
// divider, each with its start and wait state, and passes the blend and
// output states before the result is presented. Input stalls from the closing
// transfer until the result is transferred.
// Reset is synchronous; sums, round count and peak clear. Output holds in a
// register until transferred.
module inductive_line_steer_error import ilse_pkg::*; #(
  parameter int SAMPLE_BITS       = 12
) (
  input  wire  logic                   clk,
  input  wire  logic                   rst,
  input  wire  logic                   in_valid,
  output logic                         in_ready,
  input  wire  logic [SAMPLE_BITS-1:0] sample_middle,
  input  wire  logic [SAMPLE_BITS-1:0] sample_left,
  input  wire  logic [SAMPLE_BITS-1:0] sample_right,
  input  wire  logic [SAMPLE_BITS-1:0] sample_vert_left,
  input  wire  logic [SAMPLE_BITS-1:0] sample_vert_right,
  output logic                         out_valid,
  input  wire  logic                   out_ready,
  output logic signed [11:0]           steer_error,
  output logic                         line_lost,
  output logic [12:0]                  middle_peak,
  input  wire  logic                   cfg_we,
  input  wire  logic [2:0]             cfg_index,
  input  wire  logic [11:0]            cfg_data
);
  localparam int RC_BITS  = (ROUNDS_PER_RESULT > 1) ? $clog2(ROUNDS_PER_RESULT) : 1;
  localparam int SUM_BITS = SAMPLE_BITS + $clog2(ROUNDS_PER_RESULT + 1);
  // ROUNDS_PER_RESULT is a power of two so the average is a shift
  localparam int RSH      = $clog2(ROUNDS_PER_RESULT);
  localparam int DW       = 48;

  logic [11:0] max_r [NCH];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCH; i++) max_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_MIDDLE:     max_r[0] <= cfg_data;
        CFG_MAX_LEFT:       max_r[1] <= cfg_data;
        CFG_MAX_RIGHT:      max_r[2] <= cfg_data;
        CFG_MAX_VERT_LEFT:  max_r[3] <= cfg_data;
        CFG_MAX_VERT_RIGHT: max_r[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t state, state_next;
  logic [RC_BITS-1:0] round_count;
  logic [NORM_BITS-1:0] peak_middle;
  logic in_xfer;
  logic last_round;
  logic lane_start;
  logic [NCH-1:0] lane_busy;
  logic [NORM_BITS-1:0] nv [NCH];
  logic [SAMPLE_BITS-1:0] smp [NCH];

  assign smp[0] = sample_middle;
  assign smp[1] = sample_left;
  assign smp[2] = sample_right;
  assign smp[3] = sample_vert_left;
  assign smp[4] = sample_vert_right;

  assign in_ready   = (state == ST_ACC) && !out_valid;
  assign in_xfer    = in_valid && in_ready;
  assign last_round = (32'(round_count) == ROUNDS_PER_RESULT - 1);
  assign lane_start = in_xfer && last_round;

  // Lane adds this round's sample; on the closing round the sum including it
  // is needed, so fold the sample in the cycle before the divide starts.
  logic start_d;
  for (genvar g = 0; g < NCH; g++) begin : g_lane
    ilse_lane #(.SAMPLE_BITS(SAMPLE_BITS), .SUM_BITS(SUM_BITS), .RSH(RSH)) u_lane (
      .clk, .rst, .add(in_xfer), .sample(smp[g]), .start(start_d),
      .maxv(max_r[g]), .busy(lane_busy[g]), .norm(nv[g])
    );
  end

  // Shared merge divider.
  logic d_start;
  logic d_busy;
  logic [DW-1:0] d_num, d_den, d_quo;
  ilse_div #(.W(DW)) u_mdiv (
    .clk, .rst, .start(d_start), .dividend(d_num), .divisor(d_den),
    .busy(d_busy), .quotient(d_quo)
  );

  logic [NORM_BITS-1:0] m, a, b;
  logic               rneg;        // sign of current ratio
  logic signed [15:0] hr, vr;      // ratios, |r| <= 256
  logic [15:0]        comp_q;
  logic               lost;
  logic               lgr;         // left > right
  logic signed [31:0] blend;
  logic signed [31:0] err_w;
  logic [DW-1:0]      part;        // intermediate quotient magnitude
  logic [NORM_BITS-1:0] side_b;

  always_comb begin
    side_b = (state == ST_H1 || state == ST_H1W || state == ST_H2 || state == ST_H2W)
           ? nv[2] : nv[4];
  end

  always_comb begin
    state_next = state;
    d_start    = 1'b0;
    d_num      = '0;
    d_den      = '1;
    case (state)
      ST_ACC:        if (lane_start) state_next = ST_NORM_START;
      ST_NORM_START: state_next = ST_NORM_WAIT;
      ST_NORM_WAIT:  if (lane_busy == '0) state_next = ST_H1;
      ST_H1, ST_V1: begin
        d_start = 1'b1;
        d_num = DW'(256) * DW'(m) * DW'((b > a) ? (b - a) : (a - b));
        d_den = DW'(m) + DW'(a);
        state_next = (state == ST_H1) ? ST_H1W : ST_V1W;
      end
      ST_H1W: if (!d_busy) state_next = ST_H2;
      ST_V1W: if (!d_busy) state_next = ST_V2;
      ST_H2, ST_V2: begin
        d_start = 1'b1;
        d_num = part;
        d_den = DW'(m) + DW'(side_b);
        state_next = (state == ST_H2) ? ST_H2W : ST_V2W;
      end
      ST_H2W: if (!d_busy) state_next = ST_V1;
      ST_V2W: if (!d_busy) state_next = ST_COMP;
      ST_COMP: begin
        d_start = 1'b1;
        d_num = DW'(25000);
        d_den = DW'(m);
        state_next = ST_COMPW;
      end
      ST_COMPW: if (!d_busy) state_next = ST_BLEND;
      ST_BLEND: state_next = ST_OUT;
      ST_OUT:   state_next = ST_ACC;
      default:  state_next = ST_ACC;
    endcase
  end

  // Multipliers need only 13x13 bits here; m*(b-a)*256 fits 34 bits.
  always_comb begin
    a = nv[1];
    b = nv[2];
    if (state == ST_V1) begin
      a = nv[3];
      b = nv[4];
    end
    m = nv[0];
  end

  logic signed [15:0] wabs;
  logic signed [31:0] comp_s;
  assign wabs = (vr < 0) ? -vr : vr;

  // Final error before saturation: fixed +-500 when lost, else blend plus
  // low-signal compensation.
  always_comb begin
    comp_s = (m < NORM_BITS'(COMP_TH)) ? (32'(comp_q) - 32'sd20) : 32'sd0;
    if (lgr) comp_s = -comp_s;
    if (lost) err_w = lgr ? -32'sd500 : 32'sd500;
    else err_w = (blend >>> 7) + comp_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_ACC;
      round_count <= '0;
      peak_middle <= '0;
      out_valid   <= 1'b0;
      start_d     <= 1'b0;
    end else begin
      state   <= state_next;
      start_d <= lane_start;
      if (in_xfer) round_count <= last_round ? '0 : round_count + 1'b1;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == ST_OUT) begin
        out_valid <= 1'b1;
        if (nv[0] > peak_middle) middle_peak <= nv[0];
        else middle_peak <= peak_middle;
        if (nv[0] > peak_middle) peak_middle <= nv[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_NORM_WAIT: begin
        lost <= nv[0] < NORM_BITS'(LOST_TH);
        lgr  <= nv[1] > nv[2];
      end
      ST_H1: rneg <= nv[1] > nv[2];
      ST_V1: rneg <= nv[3] > nv[4];
      ST_H1W, ST_V1W: if (!d_busy && !d_start) part <= d_quo;
      ST_H2W: if (!d_busy) hr <= rneg ? -16'(d_quo) : 16'(d_quo);
      ST_V2W: if (!d_busy) vr <= rneg ? -16'(d_quo) : 16'(d_quo);
      ST_COMPW: if (!d_busy) comp_q <= 16'(d_quo);
      ST_BLEND: begin
        blend <= 32'(hr) * (32'sd200 - 32'(wabs)) + 32'(wabs) * 32'(vr);
      end
      ST_OUT: begin
        line_lost <= lost;
        if (err_w > 32'sd2047) steer_error <= 12'sd2047;
        else if (err_w < -32'sd2048) steer_error <= -12'sd2048;
        else steer_error <= err_w[11:0];
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("input accepted while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |=> out_valid)
    else $error("result not presented");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(steer_error))
    else $error("stalled result changed");
endmodule
`default_nettype wire

/* test/ilse_checker.sv */
`default_nettype none
module ilse_checker import ilse_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [11:0]        sample_middle,
  input  wire logic [11:0]        sample_left,
  input  wire logic [11:0]        sample_right,
  input  wire logic [11:0]        sample_vert_left,
  input  wire logic [11:0]        sample_vert_right,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic signed [11:0] steer_error,
  input  wire logic               line_lost,
  input  wire logic [12:0]        middle_peak,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [11:0]        cfg_data,
  output int                      mismatches,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROUNDS = 8;

  typedef struct packed {
    logic signed [11:0] steer;
    logic               lost;
    logic [12:0]        peak;
  } steer_result_t;

  steer_result_t expected_steer[$];
  logic [11:0]   cal_max[NCH];
  logic [14:0]   sums[NCH];
  int            rounds_seen;
  logic [12:0]   peak_norm;

  function automatic longint normalize_channel(logic [14:0] sum, logic [11:0] maxv);
    longint avg, lo, v;
    avg = longint'(sum) / ROUNDS;
    lo  = longint'(maxv) / 20;
    v   = (1000 * (avg - lo)) / (1000 - lo);
    if (v < 1) v = 1;
    if (v > NORM_MAX) v = NORM_MAX;
    return v;
  endfunction

  function automatic longint diff_over_sum(longint m, longint a, longint b);
    longint num;
    num = 2 * m * (b - a) * 128;
    return num / (m + a) / (m + b);
  endfunction

  function automatic steer_result_t close_block();
    longint n[NCH];
    longint err, h, v, w, comp, x, q;
    steer_result_t r;
    for (int j = 0; j < NCH; j++) begin
      n[j] = normalize_channel(sums[j], cal_max[j]);
      sums[j] = '0;
    end
    if (n[0] > longint'(peak_norm)) peak_norm = n[0][12:0];
    r.lost = 1'b0;
    if (n[0] < LOST_TH) begin
      r.lost = 1'b1;
      err = (n[1] > n[2]) ? -LOST_ERR : LOST_ERR;
    end else begin
      h = diff_over_sum(n[0], n[1], n[2]);
      v = diff_over_sum(n[0], n[3], n[4]);
      w = (v < 0) ? -v : v;
      comp = 0;
      if (n[0] < COMP_TH) begin
        comp = 25000 / n[0] - 20;
        if (n[1] > n[2]) comp = -comp;
      end
      x = h * (200 - w) + w * v;
      // floor division, not truncation
      q = x / 128;
      if ((x % 128) != 0 && x < 0) q = q - 1;
      err = q + comp;
    end
    if (err > 2047) err = 2047;
    if (err < -2048) err = -2048;
    r.steer = err[11:0];
    r.peak  = peak_norm;
    return r;
  endfunction

  assign pending = expected_steer.size();

  always @(posedge clk) begin
    steer_result_t got, want;
    if (rst) begin
      for (int j = 0; j < NCH; j++) begin
        cal_max[j] = '0;
        sums[j]    = '0;
      end
      rounds_seen = 0;
      peak_norm   = '0;
      mismatches  <= 0;
      expected_steer.delete();
    end else begin
      if (cfg_we && cfg_index < NCH) cal_max[cfg_index] = cfg_data;
      if (in_valid && in_ready) begin
        sums[0] += sample_middle;
        sums[1] += sample_left;
        sums[2] += sample_right;
        sums[3] += sample_vert_left;
        sums[4] += sample_vert_right;
        rounds_seen++;
        if (rounds_seen == ROUNDS) begin
          rounds_seen = 0;
          expected_steer.push_back(close_block());
        end
      end
      if (out_valid && out_ready) begin
        got = '{steer_error, line_lost, middle_peak};
        if (expected_steer.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: steer %0d lost %0b peak %0d",
                     steer_error, line_lost, middle_peak);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_steer.pop_front();
          if (got != want) begin
            if (mismatches < 10)
              $display("mismatch: exp steer %0d lost %0b peak %0d, got %0d %0b %0d",
                       want.steer, want.lost, want.peak,
                       steer_error, line_lost, middle_peak);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

/* test/tb_top.sv */
`default_nettype none
module tb_top import ilse_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLOCKS_PER_PHASE = 25;
  localparam int SETTLE_CYCLES    = 400;
  localparam int CYCLE_LIMIT      = 2000000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [11:0]        smp[NCH];
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [11:0] steer_error;
  logic               line_lost;
  logic [12:0]        middle_peak;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [11:0]        cfg_data = '0;
  int                 mismatches;
  int                 pending;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 cycles = 0;

  initial for (int j = 0; j < NCH; j++) smp[j] = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  inductive_line_steer_error u_top (
    .clk, .rst, .in_valid, .in_ready,
    .sample_middle(smp[0]), .sample_left(smp[1]), .sample_right(smp[2]),
    .sample_vert_left(smp[3]), .sample_vert_right(smp[4]),
    .out_valid, .out_ready, .steer_error, .line_lost, .middle_peak,
    .cfg_we, .cfg_index, .cfg_data
  );

  ilse_checker u_checker (
    .clk, .rst, .in_valid, .in_ready,
    .sample_middle(smp[0]), .sample_left(smp[1]), .sample_right(smp[2]),
    .sample_vert_left(smp[3]), .sample_vert_right(smp[4]),
    .out_valid, .out_ready, .steer_error, .line_lost, .middle_peak,
    .cfg_we, .cfg_index, .cfg_data, .mismatches, .pending
  );

  // Receiver backpressure: stall at the rate the current phase asks for.
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Present one sensor round and hold it until the transfer happens.
  task automatic send_round(input logic [11:0] r[NCH]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int j = 0; j < NCH; j++) smp[j] <= r[j];
    do @(posedge clk); while (!in_ready);
  endtask

  // Send the same round eight times, one full averaging block.
  task automatic send_flat_block(input logic [11:0] r[NCH]);
    for (int k = 0; k < 8; k++) send_round(r);
  endtask

  // Drop valid, then hold until every expected result has been transferred
  // and the block has had time to settle back to accumulating.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cal(input logic [2:0] idx, input logic [11:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all_cal(input logic [11:0] v[NCH]);
    write_cal(CFG_MAX_MIDDLE, v[0]);
    write_cal(CFG_MAX_LEFT, v[1]);
    write_cal(CFG_MAX_RIGHT, v[2]);
    write_cal(CFG_MAX_VERT_LEFT, v[3]);
    write_cal(CFG_MAX_VERT_RIGHT, v[4]);
  endtask

  // Random block: each channel gets a level near the lost-line and
  // low-signal thresholds, in the lower range, across the full range, or fully
  // random, and the rounds scatter around a level so that the averages stay meaningful.
  task automatic send_random_block();
    int          level[NCH];
    int          spread[NCH];
    int          s;
    logic [11:0] r[NCH];
    for (int j = 0; j < NCH; j++) begin
      case ($urandom_range(3))
        0: level[j] = $urandom_range(600, 150);
        1: level[j] = $urandom_range(1500);
        2: level[j] = $urandom_range(4095);
        default: level[j] = -1;
      endcase
      spread[j] = $urandom_range(40);
    end
    for (int k = 0; k < 8; k++) begin
      for (int j = 0; j < NCH; j++) begin
        if (level[j] < 0) begin
          r[j] = 12'($urandom);
        end else begin
          s = level[j] + $urandom_range(2 * spread[j]) - spread[j];
          if (s < 0) s = 0;
          if (s > 4095) s = 4095;
          r[j] = 12'(s);
        end
      end
      send_round(r);
    end
  endtask

  initial begin
    logic [11:0] cal[NCH];
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int phase = 0; phase < 6; phase++) begin
      // Calibration: reset values first, then all-ones, then random sets.
      for (int j = 0; j < NCH; j++)
        case (phase)
          0: cal[j] = 12'd0;
          1: cal[j] = 12'hfff;
          2: cal[j] = 12'($urandom_range(400));
          default: cal[j] = 12'($urandom);
        endcase
      write_all_cal(cal);

      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase

      if (phase == 0) begin
        // Silent inputs: every channel floors at 1, line lost, sides equal.
        send_flat_block('{12'd0, 12'd0, 12'd0, 12'd0, 12'd0});
        // Low middle with left above right and a strong vertical split.
        send_flat_block('{12'd400, 12'd1000, 12'd100, 12'd0, 12'd4095});
        // Every sensor saturated.
        send_flat_block('{12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff});
      end

      for (int b = 0; b < BLOCKS_PER_PHASE; b++) begin
        // Hold the sender once until the output side has fully caught up.
        if (phase == 1 && b == 10) drain();
        send_random_block();
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
